// ===== src/bpsd_pkg.sv =====
package bpsd_pkg;

  // stream payload widths
  localparam int unsigned T_IN_W      = 13;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned COORD_OUT_W = 10;
  localparam int unsigned WEIGHT_W    = 8;
  localparam int unsigned OUT_TDATA_W = 56;

  // configuration port
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_P0_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_P0_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_P1_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_P1_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_P2_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_P2_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_P3_X = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_P3_Y = 3'd7;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;

  // bounds on the sum of the four rounded weights
  localparam int unsigned WEIGHT_SUM_MIN = 253;
  localparam int unsigned WEIGHT_SUM_MAX = 257;

endpackage

// ===== src/bpsd_front.sv =====
module bpsd_front #(
  parameter int unsigned T_FRAC_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bpsd_pkg::T_IN_W-1:0]       t_frac_i,
  output logic                              q_valid_o,
  input  logic                              q_pop_i,
  output logic [T_FRAC_BITS:0]              q_t_o
);
  import bpsd_pkg::*;

  localparam int unsigned TW = T_FRAC_BITS + 1;
  localparam int unsigned EW = (T_IN_W > TW) ? T_IN_W : TW;
  localparam logic [EW-1:0] T_ONE_E = EW'(1) << T_FRAC_BITS;

  logic [EW-1:0]          t_ext;
  logic [TW-1:0]          t_sat;
  logic                   push;
  logic [TW-1:0]          q_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [Q_PTR_W:0]       count_q, count_d;

  // t above one clamps to one
  assign t_ext = EW'(t_frac_i);
  assign t_sat = (t_ext > T_ONE_E) ? TW'(T_ONE_E) : TW'(t_ext);

  assign in_ready_o = (count_q != (Q_PTR_W+1)'(Q_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_t_o      = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= t_sat;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("queue count above depth");

  a_head_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_o |-> (EW'(q_t_o) <= T_ONE_E))
    else $error("queued t above one");

  a_count_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

// ===== src/bpsd_back.sv =====
module bpsd_back #(
  parameter int unsigned COORD_BITS  = 10,
  parameter int unsigned T_FRAC_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [COORD_BITS-1:0]               px_i [4],
  input  logic [COORD_BITS-1:0]               py_i [4],
  input  logic                                q_valid_i,
  input  logic [T_FRAC_BITS:0]                q_t_i,
  output logic                                q_pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bpsd_pkg::COORD_OUT_W-1:0]    base_x_o,
  output logic [bpsd_pkg::COORD_OUT_W-1:0]    base_y_o,
  output logic [bpsd_pkg::WEIGHT_W-1:0]       weight_o [4]
);
  import bpsd_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned T  = T_FRAC_BITS;
  localparam int unsigned W  = C + T;
  localparam int unsigned MW = W + T + 3;
  localparam int unsigned PW = 2 * T + 2;
  localparam int unsigned SW = PW + WEIGHT_W;
  localparam logic [MW-1:0] LHALF = MW'(1) << (T - 1);
  localparam logic [SW-1:0] WHALF = SW'(1) << (2 * T - 1);
  localparam logic [T:0]    T_ONE = (T+1)'(1) << T;

  // first level: control points carry no fraction, so no rounding term
  function automatic logic [W-1:0] lerp0(input logic [C-1:0] a, input logic [C-1:0] b,
                                          input logic [T:0] t);
    logic signed [C:0]    diff;
    logic signed [W+2:0]  prod;
    logic [W-1:0]         base;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    base = {a, {T{1'b0}}};
    return base + prod[W-1:0];
  endfunction

  // a + round_half_up((b - a) * t / S); result stays between a and b
  function automatic logic [W-1:0] lerp(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [T:0] t);
    logic signed [W:0]    diff;
    logic signed [MW-1:0] prod;
    logic signed [MW-1:0] sh;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    sh   = (prod + $signed(LHALF)) >>> T;
    return a + sh[W-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] scale(input logic [PW-1:0] p);
    logic [SW-1:0] sc;
    sc = (SW'(p) << WEIGHT_W) - SW'(p) + WHALF;
    return sc[2*T+WEIGHT_W-1:2*T];
  endfunction

  logic            stage_en;
  logic            v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic [W-1:0]    l1x_q [3];
  logic [W-1:0]    l1y_q [3];
  logic [T:0]      t1_q, t2_q;
  logic [W-1:0]    l2x_q [2];
  logic [W-1:0]    l2y_q [2];
  logic [W-1:0]    fx_q, fy_q;
  logic [C-1:0]    bx4_q, by4_q;
  logic [PW-1:0]   prod_q [4];
  logic [T:0]      wx0, wx1, wy0, wy1;
  logic [COORD_OUT_W-1:0] bx_q, by_q;
  logic [WEIGHT_W-1:0]    w_q [4];

  // whole pipeline moves unless a finished result is held
  assign stage_en = !out_valid_q || out_ready_i;
  assign q_pop_o  = q_valid_i && stage_en;

  assign wx1 = {1'b0, fx_q[T-1:0]};
  assign wy1 = {1'b0, fy_q[T-1:0]};
  assign wx0 = T_ONE - wx1;
  assign wy0 = T_ONE - wy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (stage_en) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en) begin
      for (int i = 0; i < 3; i++) begin
        l1x_q[i] <= lerp0(px_i[i], px_i[i+1], q_t_i);
        l1y_q[i] <= lerp0(py_i[i], py_i[i+1], q_t_i);
      end
      t1_q <= q_t_i;
      for (int i = 0; i < 2; i++) begin
        l2x_q[i] <= lerp(l1x_q[i], l1x_q[i+1], t1_q);
        l2y_q[i] <= lerp(l1y_q[i], l1y_q[i+1], t1_q);
      end
      t2_q <= t1_q;
      fx_q <= lerp(l2x_q[0], l2x_q[1], t2_q);
      fy_q <= lerp(l2y_q[0], l2y_q[1], t2_q);
      bx4_q     <= fx_q[W-1:T];
      by4_q     <= fy_q[W-1:T];
      prod_q[0] <= wx0 * wy0;
      prod_q[1] <= wx0 * wy1;
      prod_q[2] <= wx1 * wy0;
      prod_q[3] <= wx1 * wy1;
      bx_q <= COORD_OUT_W'(bx4_q);
      by_q <= COORD_OUT_W'(by4_q);
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= scale(prod_q[i]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign base_x_o    = bx_q;
  assign base_y_o    = by_q;
  assign weight_o    = w_q;

  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((10'(w_q[0]) + 10'(w_q[1]) + 10'(w_q[2]) + 10'(w_q[3]) >= 10'(WEIGHT_SUM_MIN))
                  && (10'(w_q[0]) + 10'(w_q[1]) + 10'(w_q[2]) + 10'(w_q[3]) <= 10'(WEIGHT_SUM_MAX))))
    else $error("splat weights do not add up to full intensity");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stage_en && v1_q) |=> v1_q)
    else $error("item dropped from first stage during stall");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("pop from empty queue");

endmodule

// ===== src/bezier_point_splat_decasteljau.sv =====
// Cubic Bezier point splatter.
// Configure the four control points through cfg_we_i / cfg_idx_i / cfg_wdata_i
// (index 0..7 = p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y) while idle;
// an index above 7 is ignored. Then stream curve parameters t on the s_axis
// channel; each item yields one item on m_axis with the base pixel and the
// four bilinear splat weights for it and its right, lower and diagonal
// neighbours.
// Throughput: one item per cycle, set by the five-stage back pipeline
// (three de Casteljau levels, weight products, weight scaling) that moves
// every cycle the output is free.
// Path: an accepted item is stored in the input queue, then passes the back
// stages into the output register.
// Reset: control points clear to zero, queue and pipeline empty.
// Stall: when m_axis_tready_i is low the result holds and the pipeline
// freezes; input items keep landing in the 4-entry queue until it fills,
// then s_axis_tready_o drops.
module bezier_point_splat_decasteljau #(
  parameter int unsigned COORD_BITS  = 10,
  parameter int unsigned T_FRAC_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bpsd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bpsd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [12:0] t_frac, rest zero
  input  logic [bpsd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [9:0] base_x, [19:10] base_y, [27:20] weight_00, [35:28] weight_01,
  // [43:36] weight_10, [51:44] weight_11, rest zero
  output logic [bpsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import bpsd_pkg::*;

  logic [COORD_BITS-1:0]  regs_q [NUM_REGS];
  logic [COORD_BITS-1:0]  px [4];
  logic [COORD_BITS-1:0]  py [4];
  logic                   q_valid, q_pop;
  logic [T_FRAC_BITS:0]   q_t;
  logic [COORD_OUT_W-1:0] base_x, base_y;
  logic [WEIGHT_W-1:0]    weight [4];

  // control point registers; bits above COORD_BITS are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_REGS))) begin
      regs_q[cfg_idx_i[REG_IDX_W-1:0]] <= COORD_BITS'(cfg_wdata_i);
    end
  end

  always_comb begin
    px[0] = regs_q[REG_P0_X];
    px[1] = regs_q[REG_P1_X];
    px[2] = regs_q[REG_P2_X];
    px[3] = regs_q[REG_P3_X];
    py[0] = regs_q[REG_P0_Y];
    py[1] = regs_q[REG_P1_Y];
    py[2] = regs_q[REG_P2_Y];
    py[3] = regs_q[REG_P3_Y];
  end

  // front: clamp t and queue it
  bpsd_front #(
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .t_frac_i   (s_axis_tdata_i[T_IN_W-1:0]),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_t_o      (q_t)
  );

  // back: de Casteljau levels, weights, output register
  bpsd_back #(
    .COORD_BITS (COORD_BITS),
    .T_FRAC_BITS(T_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .px_i        (px),
    .py_i        (py),
    .q_valid_i   (q_valid),
    .q_t_i       (q_t),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .base_x_o    (base_x),
    .base_y_o    (base_y),
    .weight_o    (weight)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'({weight[3], weight[2], weight[1], weight[0],
                                        base_y, base_x});

endmodule
